### hw/rtl/tecm_pkg.sv
// Package: types, character constants, remap table and helpers for the text escaper.
`default_nettype none
package tecm_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3e;
  localparam logic [BYTE_W-1:0] CH_BQUOTE = 8'h60;
  localparam logic [BYTE_W-1:0] CH_Q      = 8'h51;
  localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_GT,
    KIND_BQUOTE,
    KIND_HIGH
  } kind_t;

  // One classified input byte: its kind and, for plain and high bytes, the code to emit.
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] code;
  } desc_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } beat_t;

  // Target code for high bytes, indexed by byte - 128.
  localparam logic [BYTE_W-1:0] REMAP_TAB [0:127] = '{
    8'h80, 8'h81, 8'he2, 8'hc4, 8'he3, 8'hc9, 8'ha0, 8'he0,
    8'hf6, 8'he4, 8'hb3, 8'hdc, 8'hce, 8'h8d, 8'h8e, 8'h8f,
    8'h90, 8'hd4, 8'hd5, 8'hd2, 8'hd3, 8'ha5, 8'hd0, 8'hd1,
    8'hf7, 8'haa, 8'hf0, 8'hdd, 8'hcf, 8'h9d, 8'h9e, 8'hd9,
    8'ha0, 8'hc1, 8'ha2, 8'ha3, 8'hdb, 8'hb4, 8'had, 8'ha4,
    8'hac, 8'ha9, 8'hbb, 8'hc7, 8'hc2, 8'h2d, 8'ha8, 8'hf8,
    8'hfb, 8'hb1, 8'hb7, 8'hb8, 8'hab, 8'hb5, 8'ha6, 8'he1,
    8'hfc, 8'hb6, 8'hbc, 8'hc8, 8'hb9, 8'hba, 8'hbd, 8'hc0,
    8'hcb, 8'he7, 8'he5, 8'hcc, 8'h80, 8'h81, 8'hae, 8'h82,
    8'he9, 8'h83, 8'he6, 8'he8, 8'hed, 8'hea, 8'heb, 8'hec,
    8'hc3, 8'h84, 8'hf1, 8'hee, 8'hef, 8'hcd, 8'h85, 8'hb0,
    8'haf, 8'hf4, 8'hf2, 8'hf3, 8'h86, 8'hc5, 8'hd7, 8'ha7,
    8'h88, 8'h87, 8'h89, 8'h8b, 8'h8a, 8'h8c, 8'hbe, 8'h8d,
    8'h8f, 8'h8e, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'hb2, 8'h96, 8'h98, 8'h97, 8'h99, 8'h9b, 8'h9a, 8'hd6,
    8'hbf, 8'h9d, 8'h9c, 8'h9e, 8'h9f, 8'hc6, 8'hca, 8'hd8
  };

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
    logic [BYTE_W-1:0] r;
    if (v < 4'd10) r = 8'h30 + {4'h0, v};
    else           r = 8'h57 + {4'h0, v};
    return r;
  endfunction

  // Produce beat number step of the escaped run for descriptor d.
  function automatic beat_t emit_beat(input desc_t d, input logic [STEP_W-1:0] step);
    beat_t b;
    b.data = CH_BSLASH;
    b.last = 1'b0;
    case (d.kind)
      KIND_PLAIN: begin
        b.data = d.code;
        b.last = 1'b1;
      end
      KIND_GT: begin
        if (step != '0) begin
          b.data = CH_GT;
          b.last = 1'b1;
        end
      end
      KIND_BQUOTE: begin
        if (step != '0) begin
          b.data = CH_Q;
          b.last = 1'b1;
        end
      end
      KIND_HIGH: begin
        case (step)
          3'd0:    b.data = CH_BSLASH;
          3'd1:    b.data = CH_X;
          3'd2:    b.data = hex_char(d.code[7:4]);
          3'd3:    b.data = hex_char(d.code[3:0]);
          default: begin
            b.data = CH_SPACE;
            b.last = 1'b1;
          end
        endcase
      end
      default: begin
        b.data = d.code;
        b.last = 1'b1;
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/text_escape_charset_mapper.sv
// Top level of the text escaper with high-byte charset remap.
//
// Input channel: in_valid / in_stall / in_byte, one raw text byte per beat.
// Output channel: out_valid / out_stall / out_byte / run_end; each input
// beat yields a run of one to five output beats, run_end set on the last.
// '>' and a backquote become two beats, bytes 128..255 become five beats
// (backslash, 'x', two lowercase hex digits of the remapped code, space),
// every other byte passes as one beat.
// An input beat passes through the front register, a queue slot and the
// output register before it is presented on out_byte.
// The back-stage sequencer emits one output beat per cycle unless out_stall
// holds it, so an input beat takes one, two or five output beats.
// A four-entry descriptor queue decouples the front from the back, so
// input beats keep flowing while a long run is emitted or out_stall is high.
// When out_stall is high the output register holds its beat; once the
// queue and front register fill, in_stall rises.
// Reset (rst, synchronous) empties the front register, queue and output
// register; the block carries no state across items.
`default_nettype none
module text_escape_charset_mapper
  import tecm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   run_end
);

  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;
  logic  head_valid;
  desc_t head_desc;
  logic  pop;

  tecm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  tecm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop)
  );

  tecm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_end    (run_end)
  );

endmodule
`default_nettype wire

### hw/rtl/tecm_front.sv
// Front stage: accept input beats, classify and remap them into descriptors.
`default_nettype none
module tecm_front
  import tecm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output desc_t                  push_desc
);

  logic  front_valid;
  desc_t front_desc;
  desc_t desc_next;
  logic  load;

  assign in_stall   = front_valid & ~push_ready;
  assign load       = in_valid & ~in_stall;
  assign push_valid = front_valid;
  assign push_desc  = front_desc;

  always_comb begin
    desc_next.kind = KIND_PLAIN;
    desc_next.code = in_byte;
    if (in_byte == CH_GT) begin
      desc_next.kind = KIND_GT;
    end else if (in_byte == CH_BQUOTE) begin
      desc_next.kind = KIND_BQUOTE;
    end else if (in_byte[7]) begin
      desc_next.kind = KIND_HIGH;
      desc_next.code = REMAP_TAB[in_byte[6:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (load) begin
      front_valid <= 1'b1;
    end else if (push_ready) begin
      front_valid <= 1'b0;
    end
    if (load) begin
      front_desc <= desc_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tecm_queue.sv
// Short descriptor queue between the front and back stages.
`default_nettype none
module tecm_queue
  import tecm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire desc_t push_desc,
  output logic       head_valid,
  output desc_t      head_desc,
  input  wire logic  pop
);

  desc_t             slots [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/tecm_back.sv
// Back stage: emit each descriptor's escaped run, one beat per cycle when not stalled.
`default_nettype none
module tecm_back
  import tecm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire desc_t             head_desc,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   run_end
);

  logic [STEP_W-1:0] step;
  beat_t             beat;
  logic              advance;

  assign beat    = emit_beat(head_desc, step);
  assign advance = head_valid & (~out_valid | ~out_stall);
  assign pop     = advance & beat.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= beat.last ? '0 : step + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_byte <= beat.data;
      run_end  <= beat.last;
    end
  end

endmodule
`default_nettype wire

### bench/text_escape_charset_mapper_tb.sv
// Self-checking bench for the text escaper: randomised byte stream, beat-by-beat checks.
module text_escape_charset_mapper_tb;
  import tecm_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 320;

  typedef struct {
    logic [BYTE_W-1:0] code;
    bit                drain;
  } text_item_t;

  // Target code for bytes 128..255, indexed by byte - 128.
  localparam logic [BYTE_W-1:0] CP_TARGET [0:127] = '{
    8'h80, 8'h81, 8'he2, 8'hc4, 8'he3, 8'hc9, 8'ha0, 8'he0,
    8'hf6, 8'he4, 8'hb3, 8'hdc, 8'hce, 8'h8d, 8'h8e, 8'h8f,
    8'h90, 8'hd4, 8'hd5, 8'hd2, 8'hd3, 8'ha5, 8'hd0, 8'hd1,
    8'hf7, 8'haa, 8'hf0, 8'hdd, 8'hcf, 8'h9d, 8'h9e, 8'hd9,
    8'ha0, 8'hc1, 8'ha2, 8'ha3, 8'hdb, 8'hb4, 8'had, 8'ha4,
    8'hac, 8'ha9, 8'hbb, 8'hc7, 8'hc2, 8'h2d, 8'ha8, 8'hf8,
    8'hfb, 8'hb1, 8'hb7, 8'hb8, 8'hab, 8'hb5, 8'ha6, 8'he1,
    8'hfc, 8'hb6, 8'hbc, 8'hc8, 8'hb9, 8'hba, 8'hbd, 8'hc0,
    8'hcb, 8'he7, 8'he5, 8'hcc, 8'h80, 8'h81, 8'hae, 8'h82,
    8'he9, 8'h83, 8'he6, 8'he8, 8'hed, 8'hea, 8'heb, 8'hec,
    8'hc3, 8'h84, 8'hf1, 8'hee, 8'hef, 8'hcd, 8'h85, 8'hb0,
    8'haf, 8'hf4, 8'hf2, 8'hf3, 8'h86, 8'hc5, 8'hd7, 8'ha7,
    8'h88, 8'h87, 8'h89, 8'h8b, 8'h8a, 8'h8c, 8'hbe, 8'h8d,
    8'h8f, 8'h8e, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'hb2, 8'h96, 8'h98, 8'h97, 8'h99, 8'h9b, 8'h9a, 8'hd6,
    8'hbf, 8'h9d, 8'h9c, 8'h9e, 8'h9f, 8'hc6, 8'hca, 8'hd8
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              run_end;

  text_item_t  text_pending[$];
  beat_t       escaped_due[$];
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned quiet_cycles = 0;
  text_item_t  next_text;
  beat_t       want;

  text_escape_charset_mapper dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .run_end  (run_end)
  );

  always #4 clk = ~clk;

  function automatic logic [BYTE_W-1:0] lower_hex(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + BYTE_W'(nib);
    return 8'h61 + BYTE_W'(nib - 4'd10);
  endfunction

  function automatic beat_t mk_beat(input logic [BYTE_W-1:0] data, input logic last);
    beat_t b;
    b.data = data;
    b.last = last;
    return b;
  endfunction

  // Queue the escaped run that one raw byte must produce.
  function void queue_escape_run(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] target;
    if (raw == CH_GT) begin
      escaped_due.push_back(mk_beat(CH_BSLASH, 1'b0));
      escaped_due.push_back(mk_beat(CH_GT, 1'b1));
    end else if (raw == CH_BQUOTE) begin
      escaped_due.push_back(mk_beat(CH_BSLASH, 1'b0));
      escaped_due.push_back(mk_beat(CH_Q, 1'b1));
    end else if (raw[7]) begin
      target = CP_TARGET[raw[6:0]];
      escaped_due.push_back(mk_beat(CH_BSLASH, 1'b0));
      escaped_due.push_back(mk_beat(CH_X, 1'b0));
      escaped_due.push_back(mk_beat(lower_hex(target[7:4]), 1'b0));
      escaped_due.push_back(mk_beat(lower_hex(target[3:0]), 1'b0));
      escaped_due.push_back(mk_beat(CH_SPACE, 1'b1));
    end else begin
      escaped_due.push_back(mk_beat(raw, 1'b1));
    end
  endfunction

  // Mostly short idles, now and then a long one; none during a calm stretch.
  function automatic int unsigned pick_idle(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_text_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return BYTE_W'($urandom_range(128, 255));
    if (roll < 48) return CH_GT;
    if (roll < 56) return CH_BQUOTE;
    if (roll < 60) return CH_BSLASH;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function void add_text(input logic [BYTE_W-1:0] code, input bit drain);
    text_item_t t;
    t.code  = code;
    t.drain = drain;
    text_pending.push_back(t);
  endfunction

  // Sender: take the accepted beat, then present the next byte unless held.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) queue_escape_run(in_byte);
      if ($urandom_range(0, 79) == 0) send_calm <= !send_calm;
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (text_pending.size() == 0 ||
                     (text_pending[0].drain && escaped_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          next_text = text_pending.pop_front();
          in_byte  <= next_text.code;
          in_valid <= 1'b1;
          send_gap <= pick_idle(send_calm);
        end
      end
    end
  end

  // Receiver: check each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (escaped_due.size() == 0) begin
          $error("out_byte: no beat expected, actual %02h (run_end %0b)", out_byte, run_end);
          mismatches++;
        end else begin
          want = escaped_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            mismatches++;
          end
          if (run_end !== want.last) begin
            $error("run_end: expected %0b, actual %0b", want.last, run_end);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 99) == 0) recv_calm <= !recv_calm;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        stall_left <= pick_idle(recv_calm);
        out_stall  <= 1'b0;
      end
    end
  end

  // Abort if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // Directed: plain extremes, both escapes, backslash, table edges and gaps.
    add_text(8'h00, 1'b0);
    add_text(8'h7f, 1'b0);
    add_text(CH_GT, 1'b0);
    add_text(CH_BQUOTE, 1'b0);
    add_text(CH_BSLASH, 1'b0);
    add_text(8'h80, 1'b0);
    add_text(8'hff, 1'b0);
    add_text(8'h8d, 1'b0);
    add_text(8'had, 1'b0);
    add_text(8'h9f, 1'b0);
    add_text(8'ha0, 1'b0);
    add_text(8'h3d, 1'b0);
    add_text(8'h3f, 1'b0);
    add_text(8'h5f, 1'b0);
    add_text(8'h61, 1'b0);
    add_text(CH_BQUOTE, 1'b0);
    add_text(CH_GT, 1'b0);
    add_text(8'h55, 1'b1);
    add_text(8'haa, 1'b0);
    add_text(8'hc3, 1'b0);
    add_text(8'h20, 1'b0);
    add_text(8'h01, 1'b0);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
      add_text(pick_text_byte(), (n == 110) || (n == 240));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (text_pending.size() != 0 || in_valid || escaped_due.size() != 0);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && escaped_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
